// File: design/crg_pkg.sv
// ----------------------------------------------------------------------------
// crg_pkg: shared types and constants of the camera ray generator
// Holds the word formats, the register map and the normalizer latency.
// ----------------------------------------------------------------------------
package crg_pkg;

	// Width of one vector component and the fixed-point formats built on it.
	localparam int COMP_BITS   = 16;
	localparam int POS_FRAC    = COMP_BITS - 8;
	localparam int DIR_FRAC    = COMP_BITS - 2;
	localparam int UV_FRAC     = 16;
	localparam int SIZE_FRAC   = 8;
	localparam int SCALE_FRAC  = 12;
	localparam int ORTHO_SHIFT = UV_FRAC + DIR_FRAC + SIZE_FRAC - POS_FRAC;
	localparam int PERSP_SHIFT = SCALE_FRAC + UV_FRAC;
	localparam int CFG_W       = 3 * COMP_BITS;

	// The normalizer scales every vector so its largest magnitude has this
	// many bits, then takes a square root of one bit per stage.
	localparam int NRM_BITS    = 30;
	localparam int SQRT_STEPS  = 31;
	localparam int NORM_LAT    = 6 + SQRT_STEPS + 1 + (DIR_FRAC + 1) + 1;

	// Camera kinds.
	localparam logic KIND_ORTHO = 1'b0;
	localparam logic KIND_PERSP = 1'b1;

	// Reset values of the lens registers.
	localparam logic [15:0] SIZE_RESET  = 16'd256;
	localparam logic [15:0] SCALE_RESET = 16'd8192;

	// Register map of the configuration port.
	typedef enum logic [2:0] {
		REG_CAMERA_KIND      = 3'd0,
		REG_CENTER_POSITION  = 3'd1,
		REG_DIRECTION_VECTOR = 3'd2,
		REG_UP_VECTOR        = 3'd3,
		REG_ORTHO_SIZE       = 3'd4,
		REG_VIEW_SCALE       = 3'd5
	} crg_reg_t;

	// One screen point.
	typedef struct packed {
		logic [15:0] point_u;
		logic [15:0] point_v;
	} crg_point_t;

	// One ray.
	typedef struct packed {
		logic signed [COMP_BITS-1:0] origin_x;
		logic signed [COMP_BITS-1:0] origin_y;
		logic signed [COMP_BITS-1:0] origin_z;
		logic signed [COMP_BITS-1:0] ray_dir_x;
		logic signed [COMP_BITS-1:0] ray_dir_y;
		logic signed [COMP_BITS-1:0] ray_dir_z;
		logic                        clipped;
	} crg_ray_t;

endpackage

// File: design/crg_norm.sv
// ----------------------------------------------------------------------------
// crg_norm: pipelined vector normalizer
// Scales a signed 3-vector to unit length in the direction format. The
// pipeline takes a new vector every cycle.
// ----------------------------------------------------------------------------
module crg_norm
	import crg_pkg::*;
#(
	parameter int IN_W = 33
) (
	input  logic                        clk,
	input  logic [2:0][IN_W-1:0]        vec_in,
	output logic [2:0][COMP_BITS-1:0]   vec_out
);

	localparam int PW    = $clog2(IN_W);
	localparam int SQ_W  = 2 * NRM_BITS;
	localparam int SUM_W = SQ_W + 2;
	localparam int RT_W  = SUM_W + 1;
	localparam int LEN_W = NRM_BITS + 1;
	localparam int DEN_W = LEN_W + 1;
	localparam int NUM_W = DIR_FRAC + 32;
	localparam int Q_W   = DIR_FRAC + 1;
	localparam int DSTEP = DIR_FRAC + 1;

	// Stage 1: magnitudes and signs.
	logic [IN_W-1:0] mag_s1 [3];
	logic [2:0]      neg_s1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= vec_in[i][IN_W-1];
			mag_s1[i] <= vec_in[i][IN_W-1] ? (IN_W'(0) - vec_in[i]) : vec_in[i];
		end
	end

	// Stage 2: largest magnitude.
	logic [IN_W-1:0] max_c;
	logic [IN_W-1:0] max_s2;
	logic [IN_W-1:0] mag_s2 [3];
	logic [2:0]      neg_s2;

	always_comb begin
		max_c = mag_s1[0];
		if (mag_s1[1] > max_c) begin
			max_c = mag_s1[1];
		end
		if (mag_s1[2] > max_c) begin
			max_c = mag_s1[2];
		end
	end

	always_ff @(posedge clk) begin
		max_s2 <= max_c;
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
	end

	// Stage 3: position of the leading one of the largest magnitude.
	logic [PW-1:0]   pos_c;
	logic [PW-1:0]   pos_s3;
	logic            zero_s3;
	logic [IN_W-1:0] mag_s3 [3];
	logic [2:0]      neg_s3;

	always_comb begin
		pos_c = '0;
		for (int b = 0; b < IN_W; b++) begin
			if (max_s2[b]) begin
				pos_c = PW'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s3  <= pos_c;
		zero_s3 <= (max_s2 == '0);
		mag_s3  <= mag_s2;
		neg_s3  <= neg_s2;
	end

	// Stage 4: shift so the largest magnitude lands in [2^29, 2^30).
	// mag * 2^30 >> (pos + 1) equals mag * 2^(29 - pos), truncated.
	logic [PW:0]              sh_c;
	logic [IN_W+NRM_BITS-1:0] wide_c [3];
	logic [NRM_BITS-1:0]      nm_s4 [3];
	logic                     zero_s4;
	logic [2:0]               neg_s4;

	always_comb begin
		sh_c = {1'b0, pos_s3} + 1'b1;
		for (int i = 0; i < 3; i++) begin
			wide_c[i] = {mag_s3[i], {NRM_BITS{1'b0}}} >> sh_c;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nm_s4[i] <= wide_c[i][NRM_BITS-1:0];
		end
		zero_s4 <= zero_s3;
		neg_s4  <= neg_s3;
	end

	// Stage 5: squares.
	logic [SQ_W-1:0]     sq_s5 [3];
	logic [NRM_BITS-1:0] nm_s5 [3];
	logic                zero_s5;
	logic [2:0]          neg_s5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s5[i] <= nm_s4[i] * nm_s4[i];
		end
		nm_s5   <= nm_s4;
		zero_s5 <= zero_s4;
		neg_s5  <= neg_s4;
	end

	// Stage 6: sum of squares.
	logic [SUM_W-1:0]    sum_s6;
	logic [NRM_BITS-1:0] nm_s6 [3];
	logic                zero_s6;
	logic [2:0]          neg_s6;

	always_ff @(posedge clk) begin
		sum_s6  <= SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]) + SUM_W'(sq_s5[2]);
		nm_s6   <= nm_s5;
		zero_s6 <= zero_s5;
		neg_s6  <= neg_s5;
	end

	// Square root, one result bit per stage.
	logic [RT_W-1:0]     rem_r  [SQRT_STEPS+1];
	logic [RT_W-1:0]     res_r  [SQRT_STEPS+1];
	logic [NRM_BITS-1:0] nm_r   [SQRT_STEPS+1][3];
	logic                zero_r [SQRT_STEPS+1];
	logic [2:0]          neg_r  [SQRT_STEPS+1];

	always_comb begin
		rem_r[0]  = RT_W'(sum_s6);
		res_r[0]  = '0;
		nm_r[0]   = nm_s6;
		zero_r[0] = zero_s6;
		neg_r[0]  = neg_s6;
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
		logic [RT_W-1:0] trial;

		assign trial = res_r[k] + BIT;

		always_ff @(posedge clk) begin
			if (rem_r[k] >= trial) begin
				rem_r[k+1] <= rem_r[k] - trial;
				res_r[k+1] <= (res_r[k] >> 1) + BIT;
			end else begin
				rem_r[k+1] <= rem_r[k];
				res_r[k+1] <= res_r[k] >> 1;
			end
			nm_r[k+1]   <= nm_r[k];
			zero_r[k+1] <= zero_r[k];
			neg_r[k+1]  <= neg_r[k];
		end
	end

	// Division setup: numerator 2*mag*2^F + len over denominator 2*len.
	logic [LEN_W-1:0] len_c;
	logic [NUM_W-1:0] num_r  [DSTEP+1][3];
	logic [Q_W-1:0]   quo_r  [DSTEP+1][3];
	logic [DEN_W-1:0] den_r  [DSTEP+1];
	logic             dzero_r[DSTEP+1];
	logic [2:0]       dneg_r [DSTEP+1];

	assign len_c = res_r[SQRT_STEPS][LEN_W-1:0];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_r[0][i] <= (NUM_W'(nm_r[SQRT_STEPS][i]) << (DIR_FRAC + 1)) + NUM_W'(len_c);
			quo_r[0][i] <= '0;
		end
		den_r[0]   <= {len_c, 1'b0};
		dzero_r[0] <= zero_r[SQRT_STEPS];
		dneg_r[0]  <= neg_r[SQRT_STEPS];
	end

	// Restoring division, one quotient bit per stage for each component.
	for (genvar j = 0; j < DSTEP; j++) begin : g_div
		localparam int QB = DIR_FRAC - j;
		logic [NUM_W-1:0] dsh;

		assign dsh = NUM_W'(den_r[j]) << QB;

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (num_r[j][i] >= dsh) begin
					num_r[j+1][i] <= num_r[j][i] - dsh;
					quo_r[j+1][i] <= quo_r[j][i] | (Q_W'(1) << QB);
				end else begin
					num_r[j+1][i] <= num_r[j][i];
					quo_r[j+1][i] <= quo_r[j][i];
				end
			end
			den_r[j+1]   <= den_r[j];
			dzero_r[j+1] <= dzero_r[j];
			dneg_r[j+1]  <= dneg_r[j];
		end
	end

	// Output stage: restore signs; a zero vector stays zero.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (dzero_r[DSTEP]) begin
				vec_out[i] <= '0;
			end else if (dneg_r[DSTEP][i]) begin
				vec_out[i] <= COMP_BITS'(0) - COMP_BITS'(quo_r[DSTEP][i]);
			end else begin
				vec_out[i] <= COMP_BITS'(quo_r[DSTEP][i]);
			end
		end
	end

endmodule

// File: design/camera_ray_generator.sv
// ----------------------------------------------------------------------------
// camera_ray_generator: orthographic and pinhole camera ray generation
// Turns one normalized screen point per cycle into one ray while busy is low.
// ----------------------------------------------------------------------------
// Usage:
// Load the camera through the configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high. Each write restarts the
// horizon pipeline, which normalizes direction x up, and busy stays high
// while it refills. A point is taken at each clock edge with start high and
// busy low, one per cycle with no gaps. Its ray appears on result with done
// high for one cycle; it waits on the direction normalizer, whose square
// root and divider retire one bit per stage. Results leave in order and are
// never held back: the receiver must take each word in the cycle it is shown.
// After reset the registers hold their reset values and busy is high while
// the horizon pipeline fills. Orthographic rays saturate their origin and
// clipped reports that saturation; perspective rays never clip.
// ----------------------------------------------------------------------------
module camera_ray_generator
	import crg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  crg_point_t       point,
	output logic             done,
	output crg_ray_t         result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CB      = COMP_BITS;
	localparam int XP_W    = 2 * CB + 1;
	localparam int PROD_W  = 16 + CB;
	localparam int ACC_W   = CB + 33;
	localparam int RND_W   = ACC_W + 1 - ORTHO_SHIFT;
	localparam int H_LAT   = NORM_LAT + 1;
	localparam int CNT_W   = $clog2(H_LAT + 1);
	localparam int TAIL    = NORM_LAT - 2;
	localparam int OUT_LAT = NORM_LAT + 5;
	localparam logic [RND_W-1:0] POS_MAX = RND_W'((1 << (CB - 1)) - 1);
	localparam logic [RND_W-1:0] NEG_MAX = RND_W'(1 << (CB - 1));

	typedef struct packed {
		logic               clip;
		logic [2:0][CB-1:0] org;
	} side_t;

	// Configuration registers and the horizon hold-off counter.
	logic             kind_q;
	logic [CFG_W-1:0] center_q;
	logic [CFG_W-1:0] dir_q;
	logic [CFG_W-1:0] up_q;
	logic [15:0]      size_q;
	logic [15:0]      scale_q;
	logic [CNT_W-1:0] hold_q;

	assign cfg_ready = 1'b1;
	assign busy      = (hold_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_ORTHO;
			center_q <= '0;
			dir_q    <= '0;
			up_q     <= '0;
			size_q   <= SIZE_RESET;
			scale_q  <= SCALE_RESET;
			hold_q   <= CNT_W'(H_LAT);
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (crg_reg_t'(cfg_index))
					REG_CAMERA_KIND:      kind_q   <= cfg_data[0];
					REG_CENTER_POSITION:  center_q <= cfg_data;
					REG_DIRECTION_VECTOR: dir_q    <= cfg_data;
					REG_UP_VECTOR:        up_q     <= cfg_data;
					REG_ORTHO_SIZE:       size_q   <= cfg_data[15:0];
					REG_VIEW_SCALE:       scale_q  <= cfg_data[15:0];
					default: begin
					end
				endcase
				hold_q <= CNT_W'(H_LAT);
			end else if (hold_q != '0) begin
				hold_q <= hold_q - 1'b1;
			end
		end
	end

	// Unpacked register components.
	logic signed [CB-1:0] c_c [3];
	logic signed [CB-1:0] d_c [3];
	logic signed [CB-1:0] w_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_c[i] = $signed(center_q[i*CB +: CB]);
			d_c[i] = $signed(dir_q[i*CB +: CB]);
			w_c[i] = $signed(up_q[i*CB +: CB]);
		end
	end

	// Cross product of direction and up, feeding the horizon normalizer.
	logic signed [XP_W-1:0] xa_c [3];
	logic signed [XP_W-1:0] xb_c [3];
	logic [2:0][XP_W-1:0]   xp_q;
	logic [2:0][CB-1:0]     h_vec;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xa_c[i] = d_c[(i + 1) % 3] * w_c[(i + 2) % 3];
			xb_c[i] = d_c[(i + 2) % 3] * w_c[(i + 1) % 3];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			xp_q[i] <= xa_c[i] - xb_c[i];
		end
	end

	crg_norm #(
		.IN_W(XP_W)
	) u_horizon (
		.clk    (clk),
		.vec_in (xp_q),
		.vec_out(h_vec)
	);

	// Valid bits of the item pipeline.
	logic            v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [TAIL-1:0] tv_s7;
	logic            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			tv_s7  <= '0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			tv_s7  <= {tv_s7[TAIL-2:0], v_s6};
			done_q <= tv_s7[TAIL-1];
		end
	end

	// Stage 1: center the screen point around zero.
	logic signed [15:0] du_s1, dv_s1;

	always_ff @(posedge clk) begin
		du_s1 <= {~point.point_u[15], point.point_u[14:0]};
		dv_s1 <= {~point.point_v[15], point.point_v[14:0]};
	end

	// Stage 2: offsets times horizon and up.
	logic signed [PROD_W-1:0] a_s2 [3];
	logic signed [PROD_W-1:0] b_s2 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			a_s2[i] <= du_s1 * $signed(h_vec[i]);
			b_s2[i] <= dv_s1 * w_c[i];
		end
	end

	// Stage 3: scale by the view extent or the lens factor.
	logic signed [16:0]      k_c;
	logic signed [ACC_W-1:0] pa_s3 [3];
	logic signed [ACC_W-1:0] pb_s3 [3];

	assign k_c = $signed({1'b0, (kind_q == KIND_PERSP) ? scale_q : size_q});

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pa_s3[i] <= a_s2[i] * k_c;
			pb_s3[i] <= b_s2[i] * k_c;
		end
	end

	// Stage 4: add the center (orthographic) or direction (perspective).
	logic signed [ACC_W-1:0] base_c [3];
	logic [2:0][ACC_W-1:0]   acc_s4;
	logic [2:0][CB-1:0]      n_vec;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (kind_q == KIND_PERSP) begin
				base_c[i] = d_c[i];
				base_c[i] = base_c[i] <<< PERSP_SHIFT;
			end else begin
				base_c[i] = c_c[i];
				base_c[i] = base_c[i] <<< ORTHO_SHIFT;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			acc_s4[i] <= base_c[i] + pa_s3[i] + pb_s3[i];
		end
	end

	crg_norm #(
		.IN_W(ACC_W)
	) u_direction (
		.clk    (clk),
		.vec_in (acc_s4),
		.vec_out(n_vec)
	);

	// Stage 5: round the orthographic origin, half away from zero.
	logic [ACC_W-1:0] amag_c [3];
	logic [ACC_W:0]   rsum_c [3];
	logic [RND_W-1:0] rmag_s5 [3];
	logic [2:0]       rneg_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			amag_c[i] = acc_s4[i][ACC_W-1] ? (ACC_W'(0) - acc_s4[i]) : acc_s4[i];
			rsum_c[i] = {1'b0, amag_c[i]} + ((ACC_W + 1)'(1) << (ORTHO_SHIFT - 1));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rmag_s5[i] <= rsum_c[i][ACC_W:ORTHO_SHIFT];
			rneg_s5[i] <= acc_s4[i][ACC_W-1];
		end
	end

	// Stage 6: saturate the orthographic origin; perspective keeps the center.
	side_t side_c;
	side_t side_s6;

	always_comb begin
		side_c.clip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (kind_q == KIND_PERSP) begin
				side_c.org[i] = c_c[i];
			end else if (!rneg_s5[i]) begin
				if (rmag_s5[i] > POS_MAX) begin
					side_c.org[i] = POS_MAX[CB-1:0];
					side_c.clip   = 1'b1;
				end else begin
					side_c.org[i] = rmag_s5[i][CB-1:0];
				end
			end else begin
				if (rmag_s5[i] > NEG_MAX) begin
					side_c.org[i] = NEG_MAX[CB-1:0];
					side_c.clip   = 1'b1;
				end else begin
					side_c.org[i] = CB'(0) - rmag_s5[i][CB-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s6 <= side_c;
	end

	// Delay the origin alongside the direction normalizer.
	side_t tail_s7 [TAIL];

	always_ff @(posedge clk) begin
		tail_s7[0] <= side_s6;
		for (int n = 1; n < TAIL; n++) begin
			tail_s7[n] <= tail_s7[n-1];
		end
	end

	// Output register: the normalized direction never exceeds one, so only
	// the orthographic origin can clip.
	crg_ray_t res_q;

	always_ff @(posedge clk) begin
		res_q.origin_x <= tail_s7[TAIL-1].org[0];
		res_q.origin_y <= tail_s7[TAIL-1].org[1];
		res_q.origin_z <= tail_s7[TAIL-1].org[2];
		res_q.clipped  <= tail_s7[TAIL-1].clip;
		if (kind_q == KIND_PERSP) begin
			res_q.ray_dir_x <= n_vec[0];
			res_q.ray_dir_y <= n_vec[1];
			res_q.ray_dir_z <= n_vec[2];
		end else begin
			res_q.ray_dir_x <= d_c[0];
			res_q.ray_dir_y <= d_c[1];
			res_q.ray_dir_z <= d_c[2];
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// Every accepted point later yields its ray.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##OUT_LAT done)
		else $error("ray missing after accepted point");

	// No ray without an accepted point.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, OUT_LAT))
		else $error("ray without accepted point");

	// A configuration write blocks new points while the horizon refills.
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> busy)
		else $error("not busy after configuration write");

endmodule
